// ----- rtl/core/tsvf_pkg.sv -----
`timescale 1ns / 1ps

package tsvf_pkg;

  localparam int STORE_BYTES   = 4096;
  localparam int MAX_ROWS      = 256;
  localparam int MAX_COLS      = 64;
  localparam int MAX_FIELD_OUT = 64;
  localparam int RESULT_CAP    = 63;

  localparam int FIELD_CAP = (MAX_FIELD_OUT - 1 < RESULT_CAP) ? MAX_FIELD_OUT - 1 : RESULT_CAP;

  localparam int FILL_W = $clog2(STORE_BYTES + 1);
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int ROWC_W = $clog2(MAX_ROWS + 1);
  localparam int ROWA_W = $clog2(MAX_ROWS);
  localparam int COLC_W = $clog2(MAX_COLS + 1);
  localparam int LIM_W  = $clog2(FIELD_CAP + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_COL  = 3'd1,
    ST_BAD_ROW  = 3'd2,
    ST_SHORT    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROW,
    BK_WALK_RD,
    BK_WALK_CHK,
    BK_COPY_RD,
    BK_COPY_CHK,
    BK_ERR
  } bk_state_t;

  // one queued item, already decoded by the front
  typedef struct packed {
    op_t              op;
    logic [7:0]       data_byte;
    logic [5:0]       column;
    logic [7:0]       row;
    logic [LIM_W-1:0] limit;
  } work_t;

  // queue side seen by the back
  typedef struct packed {
    logic  empty;
    work_t head;
  } q_head_t;

endpackage

// ----- rtl/core/tsv_row_index_and_field_fetch_unit.sv -----
`timescale 1ns / 1ps

// Tab-separated text index and field fetch. Load items append one byte each to
// a 4096-byte store and index rows as newlines arrive; the column count comes
// from the header line. A query returns one item per field byte with the last
// one marked, or a single item carrying an empty field or an error status.
// Loads and clears retire at one item per cycle through a four-entry queue
// while no query holds the back end. A query holds the back end to fetch its
// row start, to walk to the column and to copy each field byte, since every
// step goes through the single read port of the text store, and to reach the
// field and close it; a query failing the range checks goes straight to an
// error item. A stalled result extends that. The stores have no clearing pass:
// row and fill counts guard every read, so the block accepts items right after reset.
module tsv_row_index_and_field_fetch_unit import tsvf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  input  logic [5:0] column,
  input  logic [7:0] row,
  input  logic [6:0] max_len,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] field_byte,
  output logic       byte_valid,
  output logic       last,
  output logic [2:0] status
);

  logic    q_full;
  logic    push;
  logic    pop;
  work_t   entry;
  q_head_t q;

  tsvf_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .action    (action),
    .data_byte (data_byte),
    .column    (column),
    .row       (row),
    .max_len   (max_len),
    .q_full    (q_full),
    .push      (push),
    .entry     (entry)
  );

  tsvf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .full  (q_full),
    .pop   (pop),
    .q     (q)
  );

  tsvf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q          (q),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .field_byte (field_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .status     (status)
  );

endmodule

// ----- rtl/core/tsvf_front.sv -----
`timescale 1ns / 1ps

module tsvf_front import tsvf_pkg::*; (
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  input  logic [5:0] column,
  input  logic [7:0] row,
  input  logic [6:0] max_len,
  input  logic       q_full,
  output logic       push,
  output work_t      entry
);

  logic       accept;
  logic       keep;
  logic [6:0] len_m1;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;
  assign len_m1    = max_len - 7'd1;

  // zero-byte loads and the unused action are dropped here
  always_comb begin
    keep            = 1'b0;
    entry.op        = OP_LOAD;
    entry.data_byte = data_byte;
    entry.column    = column;
    entry.row       = row;
    entry.limit     = (max_len == 7'd0) ? '0 :
                      (len_m1 > 7'(FIELD_CAP)) ? LIM_W'(FIELD_CAP) : LIM_W'(len_m1);
    case (action_t'(action))
      ACT_LOAD: begin
        keep     = (data_byte != 8'd0);
        entry.op = OP_LOAD;
      end
      ACT_QUERY: begin
        keep     = 1'b1;
        entry.op = OP_QUERY;
      end
      ACT_CLEAR: begin
        keep     = 1'b1;
        entry.op = OP_CLEAR;
      end
      default: begin
        keep     = 1'b0;
        entry.op = OP_LOAD;
      end
    endcase
  end

  assign push = accept && keep;

endmodule

// ----- rtl/core/tsvf_queue.sv -----
`timescale 1ns / 1ps

module tsvf_queue import tsvf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  work_t   entry,
  output logic    full,
  input  logic    pop,
  output q_head_t q
);

  work_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q.empty = (count == '0);
  assign q.head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= entry;
  end

endmodule

// ----- rtl/core/tsvf_back.sv -----
`timescale 1ns / 1ps

module tsvf_back import tsvf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_head_t    q,
  output logic       pop,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] field_byte,
  output logic       byte_valid,
  output logic       last,
  output logic [2:0] status
);

  logic [7:0]        text_mem [STORE_BYTES];
  logic [FILL_W-1:0] row_mem  [MAX_ROWS];  // holds offsets up to STORE_BYTES itself

  logic [7:0]        st_rdata;
  logic [FILL_W-1:0] row_rdata;

  bk_state_t         state;
  bk_state_t         state_next;

  logic [FILL_W-1:0] fill_count;
  logic [ROWC_W-1:0] row_count;
  logic [COLC_W-1:0] column_count;
  logic              header_done;
  logic              overflow_flag;

  logic [FILL_W-1:0] pos;
  logic [5:0]        tabs;
  logic [5:0]        col_q;
  logic [LIM_W-1:0]  lim_q;
  logic [LIM_W-1:0]  n;
  logic [7:0]        pending;
  status_t           err_status;

  work_t             head;
  logic              slot_free;
  logic              is_load;
  logic              is_nl;
  logic              is_tab;
  logic              load_ok;
  logic              at_end;
  logic              copy_more;
  logic              is_term;
  status_t           chk_status;

  logic              emit;
  logic [7:0]        emit_byte;
  logic              emit_valid;
  logic              emit_last;
  status_t           emit_status;

  assign head      = q.head;
  assign slot_free = !rsp_valid || !rsp_stall;

  assign is_load = pop && (head.op == OP_LOAD);
  assign is_nl   = (head.data_byte == CH_NL);
  assign is_tab  = (head.data_byte == CH_TAB);
  assign load_ok = !overflow_flag && (fill_count < FILL_W'(STORE_BYTES)) &&
                   !(is_nl && (row_count >= ROWC_W'(MAX_ROWS)));

  assign at_end    = (pos >= fill_count);
  assign copy_more = (n < lim_q) && !at_end;
  assign is_term   = (st_rdata == CH_TAB) || (st_rdata == CH_NL);

  always_comb begin
    if (overflow_flag)                                chk_status = ST_OVERFLOW;
    else if (COLC_W'(head.column) >= column_count)    chk_status = ST_BAD_COL;
    else if (ROWC_W'(head.row) >= row_count)          chk_status = ST_BAD_ROW;
    else                                              chk_status = ST_OK;
  end

  // store reads; only entries below the fill marks are ever examined
  always_ff @(posedge clk) begin
    st_rdata  <= text_mem[pos[ADDR_W-1:0]];
    row_rdata <= row_mem[ROWA_W'(head.row)];
  end

  always_ff @(posedge clk) begin
    if (is_load && load_ok) begin
      text_mem[fill_count[ADDR_W-1:0]] <= head.data_byte;
      if (is_nl) row_mem[row_count[ROWA_W-1:0]] <= fill_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      row_count     <= '0;
      column_count  <= '0;
      header_done   <= 1'b0;
      overflow_flag <= 1'b0;
    end else if (pop) begin
      case (head.op)
        OP_CLEAR: begin
          fill_count    <= '0;
          row_count     <= '0;
          column_count  <= '0;
          header_done   <= 1'b0;
          overflow_flag <= 1'b0;
        end
        OP_LOAD: begin
          if (!overflow_flag) begin
            if (!load_ok) begin
              overflow_flag <= 1'b1;
            end else begin
              fill_count <= fill_count + 1'b1;
              if (is_tab && !header_done && column_count < COLC_W'(MAX_COLS))
                column_count <= column_count + 1'b1;
              if (is_nl) begin
                row_count <= row_count + 1'b1;
                if (!header_done) begin
                  header_done <= 1'b1;
                  if (column_count < COLC_W'(MAX_COLS)) column_count <= column_count + 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (pop && head.op == OP_QUERY)
          state_next = (chk_status != ST_OK) ? BK_ERR : BK_ROW;
      end
      BK_ROW:      state_next = BK_WALK_RD;
      BK_WALK_RD: begin
        if (tabs == col_q) state_next = BK_COPY_RD;
        else if (at_end)   state_next = BK_ERR;
        else               state_next = BK_WALK_CHK;
      end
      BK_WALK_CHK: state_next = (st_rdata == CH_NL) ? BK_ERR : BK_WALK_RD;
      BK_COPY_RD: begin
        if (copy_more)  state_next = BK_COPY_CHK;
        else if (emit)  state_next = BK_IDLE;
      end
      BK_COPY_CHK: begin
        if (is_term) begin
          if (emit) state_next = BK_IDLE;
        end else if (n == '0 || emit) begin
          state_next = BK_COPY_RD;
        end
      end
      BK_ERR:      if (emit) state_next = BK_IDLE;
      default:     state_next = BK_IDLE;
    endcase
  end

  // a field byte is held back one step so the final one can carry last
  always_comb begin
    pop         = 1'b0;
    emit        = 1'b0;
    emit_byte   = 8'd0;
    emit_valid  = 1'b0;
    emit_last   = 1'b0;
    emit_status = ST_OK;
    case (state)
      BK_IDLE: pop = !q.empty;
      BK_COPY_RD: begin
        if (!copy_more) begin
          emit       = slot_free;
          emit_byte  = (n != '0) ? pending : 8'd0;
          emit_valid = (n != '0);
          emit_last  = 1'b1;
        end
      end
      BK_COPY_CHK: begin
        if (is_term) begin
          emit       = slot_free;
          emit_byte  = (n != '0) ? pending : 8'd0;
          emit_valid = (n != '0);
          emit_last  = 1'b1;
        end else if (n != '0) begin
          emit       = slot_free;
          emit_byte  = pending;
          emit_valid = 1'b1;
        end
      end
      BK_ERR: begin
        emit        = slot_free;
        emit_last   = 1'b1;
        emit_status = err_status;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        col_q      <= head.column;
        lim_q      <= head.limit;
        err_status <= chk_status;
      end
      BK_ROW: begin
        pos  <= row_rdata;
        tabs <= '0;
        n    <= '0;
      end
      BK_WALK_RD:  if (tabs != col_q && at_end) err_status <= ST_SHORT;
      BK_WALK_CHK: begin
        if (st_rdata == CH_NL) begin
          err_status <= ST_SHORT;
        end else begin
          if (st_rdata == CH_TAB) tabs <= tabs + 1'b1;
          pos <= pos + 1'b1;
        end
      end
      BK_COPY_CHK: begin
        if (!is_term && (n == '0 || emit)) begin
          pending <= st_rdata;
          n       <= n + 1'b1;
          pos     <= pos + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)             rsp_valid <= 1'b0;
    else if (emit)       rsp_valid <= 1'b1;
    else if (!rsp_stall) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      field_byte <= emit_byte;
      byte_valid <= emit_valid;
      last       <= emit_last;
      status     <= emit_status;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(STORE_BYTES))
    else $error("fill count beyond store size");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row_count <= ROWC_W'(MAX_ROWS))
    else $error("row count beyond table size");

  a_hdr_cols: assert property (@(posedge clk) disable iff (rst)
    header_done |-> column_count != '0)
    else $error("header done with no columns");

  a_busy_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE) |-> !pop)
    else $error("queue popped during a query");

  a_ovf_frozen: assert property (@(posedge clk) disable iff (rst)
    (overflow_flag && !(pop && head.op == OP_CLEAR)) |=> $stable(fill_count))
    else $error("store grew after overflow");
`endif

endmodule
